### rtl/core/ihsr_pkg.sv
`default_nettype none

package ihsr_pkg;

  // bus sequencer phases
  typedef enum logic [4:0] {
    PH_IDLE,
    PH_ST0,
    PH_ST1,
    PH_ST2,
    PH_WLO,
    PH_WHI,
    PH_R1LO,
    PH_R1HI,
    PH_R2LO,
    PH_R2HI,
    PH_ALO,
    PH_AHI,
    PH_NLO,
    PH_NHI,
    PH_WAIT,
    PH_GAP,
    PH_SP0,
    PH_SP1,
    PH_SP2
  } ihsr_phase_t;

  // transaction kinds
  localparam logic [2:0] KIND_HOLD_MEAS = 3'd0;
  localparam logic [2:0] KIND_POLL_MEAS = 3'd1;
  localparam logic [2:0] KIND_REG_READ  = 3'd2;
  localparam logic [2:0] KIND_REG_WRITE = 3'd3;

  // byte positions within a transaction
  localparam logic [1:0] BYTE_ADDR    = 2'd0;
  localparam logic [1:0] BYTE_CMD     = 2'd1;
  localparam logic [1:0] BYTE_THIRD   = 2'd2;
  localparam logic [1:0] BYTE_READING = 2'd3;

  // configuration register indexes
  localparam logic [1:0] CFG_SLAVE_ADDRESS  = 2'd0;
  localparam logic [1:0] CFG_HALF_BIT_TICKS = 2'd1;
  localparam logic [1:0] CFG_POLL_GAP_TICKS = 2'd2;

  // configuration reset values
  localparam logic [6:0]  RST_SLAVE_ADDRESS  = 7'd64;
  localparam logic [15:0] RST_HALF_BIT_TICKS = 16'd80;
  localparam logic [15:0] RST_POLL_GAP_TICKS = 16'd20;

  // bit count of a byte and data bit that goes out first
  localparam logic [3:0] BITS_PER_BYTE = 4'd8;
  localparam logic [3:0] LAST_READ_BIT = 4'd7;
  localparam logic [7:0] MSB_MASK      = 8'h80;

  // measurement status bits cleared from the reading
  localparam logic [15:0] STATUS_MASK = 16'h0003;

  // conversion: round(raw * coef / 100000) - offset
  localparam logic [18:0] COEF_TEMP  = 19'd268127;
  localparam logic [18:0] COEF_HUMID = 19'd190735;
  localparam logic [34:0] ROUND_HALF = 35'd50000;
  localparam logic [19:0] OFFS_TEMP  = 20'd4685;
  localparam logic [19:0] OFFS_HUMID = 20'd600;

  // division by 100000 = shift by 5, then by 3125 through a reciprocal
  localparam int unsigned PRE_SHIFT   = 5;
  localparam int unsigned RECIP_SHIFT = 41;
  localparam logic [29:0] RECIP_3125  = 30'd703687441;
  localparam logic [11:0] DIV_3125    = 12'd3125;

  // saturation bounds of the scaled reading
  localparam logic signed [19:0] SCALED_MAX = 20'sd12500;
  localparam logic signed [19:0] SCALED_MIN = -20'sd4685;

  // one input item
  typedef struct packed {
    logic       cmd;
    logic [2:0] kind;
    logic [7:0] code;
    logic [7:0] wval;
    logic       humid;
    logic       scl;
    logic       sda;
  } ihsr_item_t;

  // configuration registers
  typedef struct packed {
    logic [6:0]  slave_address;
    logic [15:0] half_bit_ticks;
    logic [15:0] poll_gap_ticks;
  } ihsr_cfg_t;

  // sequencer result handed to the conversion pipeline
  typedef struct packed {
    logic        scl_low;
    logic        sda_low;
    logic        busy;
    logic        done;
    logic        ack_missing;
    logic [15:0] raw;
    logic        conv;
    logic        humid;
  } ihsr_seq_res_t;

endpackage

`default_nettype wire

### rtl/core/ihsr_sequencer.sv
`default_nettype none

module ihsr_sequencer (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   adv,
  input  wire                   acc,
  input  ihsr_pkg::ihsr_item_t  item,
  input  ihsr_pkg::ihsr_cfg_t   cfg,
  output logic                  res_valid,
  output ihsr_pkg::ihsr_seq_res_t res
);
  import ihsr_pkg::*;

  ihsr_phase_t   phase_r, phase_nxt;
  logic [15:0]   tick_r, tick_nxt;
  logic [3:0]    bit_r, bit_nxt;
  logic [1:0]    byte_r, byte_nxt;
  logic [7:0]    shift_r, shift_nxt;
  logic [15:0]   capt_r, capt_nxt;
  logic [2:0]    kind_r, kind_nxt;
  logic [7:0]    code_r, code_nxt;
  logic [7:0]    wval_r, wval_nxt;
  logic          humid_r, humid_nxt;
  logic          ack_r, ack_nxt;
  logic          res_valid_r;
  ihsr_seq_res_t res_r, res_nxt;

  logic [15:0]   len_sel;
  logic [15:0]   len_eff;
  logic          tick_end;
  logic          wr_bit_low;
  logic          ack_now;

  // step length and end of step
  always_comb begin
    len_sel  = (phase_r == PH_GAP) ? cfg.poll_gap_ticks : cfg.half_bit_ticks;
    len_eff  = (len_sel == 16'd0) ? 16'd1 : len_sel;
    tick_end = (({1'b0, tick_r} + 17'd1) >= {1'b0, len_eff});
    wr_bit_low = (bit_r < BITS_PER_BYTE) && ((shift_r & MSB_MASK) == 8'd0);
    ack_now = item.sda;
  end

  // next state and result of one item
  always_comb begin
    phase_nxt = phase_r;
    tick_nxt  = tick_r;
    bit_nxt   = bit_r;
    byte_nxt  = byte_r;
    shift_nxt = shift_r;
    capt_nxt  = capt_r;
    kind_nxt  = kind_r;
    code_nxt  = code_r;
    wval_nxt  = wval_r;
    humid_nxt = humid_r;
    ack_nxt   = ack_r;
    res_nxt   = '0;
    res_nxt.humid = humid_r;

    // drive levels follow the phase held before this item
    unique case (phase_r)
      PH_ST0, PH_R1LO, PH_R2LO, PH_GAP, PH_NLO: res_nxt.scl_low = 1'b1;
      PH_ST2, PH_AHI, PH_SP1:                    res_nxt.sda_low = 1'b1;
      PH_WLO: begin
        res_nxt.scl_low = 1'b1;
        res_nxt.sda_low = wr_bit_low;
      end
      PH_WHI:         res_nxt.sda_low = wr_bit_low;
      PH_ALO, PH_SP0: begin
        res_nxt.scl_low = 1'b1;
        res_nxt.sda_low = 1'b1;
      end
      default: ;
    endcase

    if (item.cmd) begin
      // begin command, ignored while a transaction runs
      if (phase_r == PH_IDLE) begin
        kind_nxt  = item.kind;
        code_nxt  = item.code;
        wval_nxt  = item.wval;
        humid_nxt = item.humid;
        phase_nxt = PH_ST0;
        tick_nxt  = 16'd0;
        bit_nxt   = 4'd0;
        byte_nxt  = BYTE_ADDR;
        shift_nxt = 8'd0;
        capt_nxt  = 16'd0;
        ack_nxt   = 1'b0;
      end
    end else if (phase_r == PH_WAIT) begin
      // hold mode: wait for the slave to release the clock
      if (item.scl) begin
        bit_nxt   = 4'd0;
        tick_nxt  = 16'd0;
        phase_nxt = PH_R1LO;
      end
    end else if (phase_r != PH_IDLE) begin
      if (!tick_end) begin
        tick_nxt = tick_r + 16'd1;
      end else begin
        tick_nxt = 16'd0;
        unique case (phase_r)
          PH_ST0: phase_nxt = PH_ST1;
          PH_ST1: phase_nxt = PH_ST2;
          PH_ST2: begin
            shift_nxt = {cfg.slave_address, (byte_r != BYTE_ADDR)};
            bit_nxt   = 4'd0;
            phase_nxt = PH_WLO;
          end
          PH_WLO: phase_nxt = PH_WHI;
          PH_WHI: begin
            if (bit_r >= BITS_PER_BYTE) begin
              // acknowledge slot of a written byte
              ack_nxt = ack_now;
              priority case (byte_r)
                BYTE_ADDR: begin
                  byte_nxt  = BYTE_CMD;
                  shift_nxt = code_r;
                  bit_nxt   = 4'd0;
                  phase_nxt = PH_WLO;
                end
                BYTE_CMD: begin
                  byte_nxt = BYTE_THIRD;
                  if (kind_r == KIND_HOLD_MEAS || kind_r == KIND_REG_READ) begin
                    phase_nxt = PH_ST0;
                  end else if (kind_r == KIND_POLL_MEAS) begin
                    phase_nxt = PH_GAP;
                  end else if (kind_r == KIND_REG_WRITE) begin
                    shift_nxt = wval_r;
                    bit_nxt   = 4'd0;
                    phase_nxt = PH_WLO;
                  end else begin
                    phase_nxt = PH_SP0;
                  end
                end
                default: begin
                  if (kind_r == KIND_POLL_MEAS && ack_now) begin
                    // no acknowledge on the read address: retry after a gap
                    byte_nxt  = BYTE_THIRD;
                    phase_nxt = PH_GAP;
                  end else begin
                    byte_nxt = BYTE_READING;
                    if (kind_r == KIND_HOLD_MEAS) begin
                      phase_nxt = PH_WAIT;
                    end else if (kind_r == KIND_POLL_MEAS || kind_r == KIND_REG_READ) begin
                      bit_nxt   = 4'd0;
                      phase_nxt = PH_R1LO;
                    end else begin
                      phase_nxt = PH_SP0;
                    end
                  end
                end
              endcase
            end else begin
              shift_nxt = {shift_r[6:0], 1'b0};
              bit_nxt   = bit_r + 4'd1;
              phase_nxt = PH_WLO;
            end
          end
          PH_R1LO: phase_nxt = PH_R1HI;
          PH_R2LO: phase_nxt = PH_R2HI;
          PH_R1HI, PH_R2HI: begin
            capt_nxt = {capt_r[14:0], item.sda};
            if (bit_r < LAST_READ_BIT) begin
              bit_nxt   = bit_r + 4'd1;
              phase_nxt = (phase_r == PH_R1HI) ? PH_R1LO : PH_R2LO;
            end else begin
              bit_nxt = 4'd0;
              if (phase_r == PH_R1HI && kind_r != KIND_REG_READ) begin
                phase_nxt = PH_ALO;
              end else begin
                phase_nxt = PH_NLO;
              end
            end
          end
          PH_ALO: phase_nxt = PH_AHI;
          PH_AHI: begin
            bit_nxt   = 4'd0;
            phase_nxt = PH_R2LO;
          end
          PH_NLO: phase_nxt = PH_NHI;
          PH_NHI: phase_nxt = PH_SP0;
          PH_GAP: phase_nxt = PH_ST0;
          PH_SP0: phase_nxt = PH_SP1;
          PH_SP1: phase_nxt = PH_SP2;
          default: begin
            // end of stop condition: report the transaction
            phase_nxt    = PH_IDLE;
            res_nxt.done = 1'b1;
            if (kind_r == KIND_HOLD_MEAS || kind_r == KIND_POLL_MEAS) begin
              res_nxt.raw  = capt_r & ~STATUS_MASK;
              res_nxt.conv = 1'b1;
            end else if (kind_r == KIND_REG_READ) begin
              res_nxt.raw = {8'd0, capt_r[7:0]};
            end
          end
        endcase
      end
    end

    res_nxt.busy        = (phase_nxt != PH_IDLE);
    res_nxt.ack_missing = ack_nxt;
  end

  // sequencer state, advanced by each accepted item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      tick_r  <= 16'd0;
      bit_r   <= 4'd0;
      byte_r  <= BYTE_ADDR;
      shift_r <= 8'd0;
      capt_r  <= 16'd0;
      kind_r  <= 3'd0;
      code_r  <= 8'd0;
      wval_r  <= 8'd0;
      humid_r <= 1'b0;
      ack_r   <= 1'b0;
    end else if (acc) begin
      phase_r <= phase_nxt;
      tick_r  <= tick_nxt;
      bit_r   <= bit_nxt;
      byte_r  <= byte_nxt;
      shift_r <= shift_nxt;
      capt_r  <= capt_nxt;
      kind_r  <= kind_nxt;
      code_r  <= code_nxt;
      wval_r  <= wval_nxt;
      humid_r <= humid_nxt;
      ack_r   <= ack_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_valid_r <= 1'b0;
    end else if (adv) begin
      res_valid_r <= acc;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res_r <= res_nxt;
    end
  end

  assign res_valid = res_valid_r;
  assign res       = res_r;

  // a finished transaction leaves the block idle
  a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid_r && res_r.done |-> !res_r.busy)
    else $error("done reported while still busy");

  // readings appear only with done
  a_raw_only_on_done: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid_r && !res_r.done |-> (res_r.raw == 16'd0) && !res_r.conv)
    else $error("reading outside the completing item");

  // reading phases never start before the read address byte
  a_read_after_addr: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_R1LO || phase_r == PH_R2LO || phase_r == PH_WAIT)
      |-> (byte_r == BYTE_READING))
    else $error("read phase entered before address phase completed");

endmodule

`default_nettype wire

### rtl/core/ihsr_convert.sv
`default_nettype none

module ihsr_convert (
  input  wire                     clk,
  input  wire                     rst_n,
  input  wire                     adv,
  input  wire                     in_valid,
  input  ihsr_pkg::ihsr_seq_res_t in_res,
  output logic                    out_valid,
  output ihsr_pkg::ihsr_seq_res_t out_res,
  output logic signed [14:0]      out_scaled
);
  import ihsr_pkg::*;

  // stage valid bits
  logic          v2_r, v3_r, v4_r, v5_r;
  ihsr_seq_res_t r2_r, r3_r, r4_r, r5_r;

  // stage 2: scaled product plus one half
  logic [34:0]   prod_r;
  // stage 3: quotient estimate by reciprocal
  logic [29:0]   y3_r;
  logic [18:0]   q3_r;
  // stage 4: back multiplication for the remainder
  logic [29:0]   y4_r;
  logic [18:0]   q4_r;
  logic [29:0]   m4_r;
  // stage 5: corrected, offset and saturated reading
  logic signed [14:0] scaled_r;

  logic [18:0]   coef;
  logic [29:0]   y_cur;
  logic [59:0]   recip_prod;
  logic [29:0]   rem;
  logic [18:0]   q_fix;
  logic [19:0]   offs;
  logic signed [19:0] val;
  logic signed [14:0] sat;

  always_comb begin
    coef       = in_res.humid ? COEF_HUMID : COEF_TEMP;
    y_cur      = prod_r[34:PRE_SHIFT];
    recip_prod = {30'd0, y_cur} * {30'd0, RECIP_3125};
    rem        = y4_r - m4_r;
    q_fix      = q4_r + {18'd0, (rem >= {18'd0, DIV_3125})};
    offs       = r4_r.humid ? OFFS_HUMID : OFFS_TEMP;
    val        = $signed({1'b0, q_fix}) - $signed(offs);
    if (val > SCALED_MAX) begin
      sat = SCALED_MAX[14:0];
    end else if (val < SCALED_MIN) begin
      sat = SCALED_MIN[14:0];
    end else begin
      sat = val[14:0];
    end
  end

  // valid bits of the pipeline
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else if (adv) begin
      v2_r <= in_valid;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
    end
  end

  // payload stages
  always_ff @(posedge clk) begin
    if (adv) begin
      r2_r     <= in_res;
      prod_r   <= ({16'd0, coef} * {19'd0, in_res.raw}) + ROUND_HALF;
      r3_r     <= r2_r;
      y3_r     <= y_cur;
      q3_r     <= 19'(recip_prod >> RECIP_SHIFT);
      r4_r     <= r3_r;
      y4_r     <= y3_r;
      q4_r     <= q3_r;
      m4_r     <= 30'({11'd0, q3_r} * {18'd0, DIV_3125});
      r5_r     <= r4_r;
      scaled_r <= r4_r.conv ? sat : 15'sd0;
    end
  end

  assign out_valid  = v5_r;
  assign out_res    = r5_r;
  assign out_scaled = scaled_r;

  // estimate is at most one below the true quotient
  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    v4_r |-> (rem < {17'd0, DIV_3125, 1'b0}))
    else $error("reciprocal estimate out of range");

  // reading stays inside its range
  a_scaled_range: assert property (@(posedge clk) disable iff (!rst_n)
    v5_r |-> (scaled_r >= $signed(SCALED_MIN[14:0])) &&
             (scaled_r <= $signed(SCALED_MAX[14:0])))
    else $error("scaled reading outside its range");

  // only measurements carry a scaled reading
  a_scaled_only_conv: assert property (@(posedge clk) disable iff (!rst_n)
    v5_r && !r5_r.conv |-> (scaled_r == 15'sd0))
    else $error("scaled reading without a measurement");

endmodule

`default_nettype wire

### rtl/core/i2c_humidity_sensor_reader.sv
// I2C master for a humidity / temperature sensor.
// Input channel (in_*): one transfer per tick or begin command. in_tuser = 1 starts a
// transaction with the kind, command byte, write byte and conversion in in_tdata;
// in_tuser = 0 is a time tick carrying the sampled SCL and SDA levels.
// Result channel (out_*): exactly one transfer per input transfer, in order, with the
// pull-low levels for both lines, busy, a one-item done pulse, the acknowledge error
// and, on done, the raw and scaled readings.
// Configuration (cfg_*): slave address, ticks per half bit and poll gap; write only
// while no transfer is in the pipeline. cfg_ready is always high.
// Path: the result of an item passes through the sequencer result register and then
// a four-stage conversion pipeline before it appears on out_*.
// Throughput: one item per cycle while the output is not held, set by the sequencer
// state register that takes one tick per cycle; a new item is accepted while earlier
// ones are in the pipeline. When out_tready is low with a result waiting the whole
// pipeline holds and in_tready falls in the same cycle; no result is lost or repeated.
// Reset (rst_n low, synchronous): sequencer idle, pipeline empty, configuration
// back to address 64, 80 ticks per half bit and a gap of 20 ticks.
`default_nettype none

module i2c_humidity_sensor_reader (
  input  wire         clk,
  input  wire         rst_n,
  // input channel
  input  wire         in_tvalid,
  output logic        in_tready,
  // [2:0] transaction_kind, [10:3] command_code, [18:11] write_value,
  // [19] is_humidity, [20] scl_sample, [21] sda_sample, [23:22] zero
  input  wire  [23:0] in_tdata,
  // [0] cmd
  input  wire  [0:0]  in_tuser,
  // result channel
  output logic        out_tvalid,
  input  wire         out_tready,
  // [0] scl_pull_low, [1] sda_pull_low, [2] busy_res, [3] done_res, [4] ack_missing,
  // [20:5] raw_reading, [35:21] scaled_reading, [39:36] zero
  output logic [39:0] out_tdata,
  // configuration channel
  input  wire         cfg_valid,
  output logic        cfg_ready,
  input  wire  [1:0]  cfg_index,
  input  wire  [15:0] cfg_data
);
  import ihsr_pkg::*;

  ihsr_cfg_t     cfg_r;
  ihsr_item_t    item;
  logic          adv;
  logic          acc;
  logic          seq_valid;
  ihsr_seq_res_t seq_res;
  logic          conv_valid;
  ihsr_seq_res_t conv_res;
  logic signed [14:0] conv_scaled;

  // pipeline moves when the output register is free or being emptied
  assign adv       = !conv_valid || out_tready;
  assign in_tready = adv;
  assign acc       = in_tvalid && adv;
  assign cfg_ready = 1'b1;

  // unpack the input transfer
  always_comb begin
    item.cmd   = in_tuser[0];
    item.kind  = in_tdata[2:0];
    item.code  = in_tdata[10:3];
    item.wval  = in_tdata[18:11];
    item.humid = in_tdata[19];
    item.scl   = in_tdata[20];
    item.sda   = in_tdata[21];
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.slave_address  <= RST_SLAVE_ADDRESS;
      cfg_r.half_bit_ticks <= RST_HALF_BIT_TICKS;
      cfg_r.poll_gap_ticks <= RST_POLL_GAP_TICKS;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_SLAVE_ADDRESS:  cfg_r.slave_address  <= cfg_data[6:0];
        CFG_HALF_BIT_TICKS: cfg_r.half_bit_ticks <= cfg_data;
        CFG_POLL_GAP_TICKS: cfg_r.poll_gap_ticks <= cfg_data;
        default: ;
      endcase
    end
  end

  ihsr_sequencer u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .acc       (acc),
    .item      (item),
    .cfg       (cfg_r),
    .res_valid (seq_valid),
    .res       (seq_res)
  );

  ihsr_convert u_conv (
    .clk        (clk),
    .rst_n      (rst_n),
    .adv        (adv),
    .in_valid   (seq_valid),
    .in_res     (seq_res),
    .out_valid  (conv_valid),
    .out_res    (conv_res),
    .out_scaled (conv_scaled)
  );

  // pack the result transfer
  assign out_tvalid = conv_valid;
  assign out_tdata  = {4'd0, conv_scaled, conv_res.raw, conv_res.ack_missing,
                       conv_res.done, conv_res.busy, conv_res.sda_low, conv_res.scl_low};

endmodule

`default_nettype wire
